// ----- src/rlsc_pkg.sv -----
`timescale 1ns / 1ps
package rlsc_pkg;

    localparam int SAMPLE_W        = 10;
    localparam int ANGLE_W         = 15;
    localparam int DIST_W          = 14;
    localparam int SENSOR_COUNT_DEF = 30;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd700;

endpackage

// ----- src/rlsc_sample_if.sv -----
`timescale 1ns / 1ps
interface rlsc_sample_if;
    logic                          valid;
    logic                          ready;
    logic [rlsc_pkg::SAMPLE_W-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// ----- src/rlsc_result_if.sv -----
`timescale 1ns / 1ps
interface rlsc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [rlsc_pkg::ANGLE_W-1:0] chord_angle;
    logic [rlsc_pkg::DIST_W-1:0]         chord_distance;
    logic                                result_valid;

    modport source (output valid, output chord_angle, output chord_distance,
                    output result_valid, input ready);
    modport sink (input valid, input chord_angle, input chord_distance,
                  input result_valid, output ready);
endinterface

// ----- src/ring_line_sensor_chord_locator.sv -----
`timescale 1ns / 1ps
// Chord locator for a ring of light sensors.
// The samples channel takes one reading per transfer in sensor index order;
// last_sample marks the final sensor of a ring and starts the evaluation.
// A sample is taken in each cycle while the block is loading. After the
// final transfer the sequencer scans the lit map one sensor per cycle, then
// the angle and distance are read from constant tables into the output
// register once it is free, and that register drives the results channel.
// The samples channel is not ready from the final transfer until the result
// has been moved into the output register.
// If the receiver stalls, the result holds on the results channel and the
// next ring may load meanwhile; its evaluation waits for the register.
// Reset clears the lit map and the position, sets the threshold to 700 and
// empties the output register. cfg_we writes the threshold; the user must do
// so only while idle, as the block itself does not enforce this.
module ring_line_sensor_chord_locator #(
    parameter int SENSOR_COUNT = rlsc_pkg::SENSOR_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rlsc_pkg::SAMPLE_W-1:0] cfg_data,
    rlsc_sample_if.sink                   samples,
    rlsc_result_if.source                 results
);
    import rlsc_pkg::*;

    localparam int LW     = $clog2(SENSOR_COUNT);
    localparam int HALF   = SENSOR_COUNT / 2;
    localparam int DW     = $clog2(HALF + 1);
    localparam longint unsigned PI_Q29 = 64'd1686629713;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned DEN    = longint'(SENSOR_COUNT) << 16;
    localparam longint unsigned N_L    = longint'(SENSOR_COUNT);

    typedef logic [ANGLE_W-1:0] ang_tab_t [SENSOR_COUNT];
    typedef logic [DIST_W-1:0]  dist_tab_t [HALF+1];

    function automatic ang_tab_t build_ang();
        ang_tab_t         tab;
        longint unsigned  mag;
        for (int k = 0; k < SENSOR_COUNT; k++)
        begin
            if (2 * k < SENSOR_COUNT)
            begin
                mag    = (longint'(k) * PI_Q29 + DEN / 2) / DEN;
                tab[k] = ANGLE_W'(mag);
            end
            else
            begin
                mag    = (longint'(SENSOR_COUNT - k) * PI_Q29 + DEN / 2) / DEN;
                tab[k] = ANGLE_W'(64'd0 - mag);
            end
        end
        return tab;
    endfunction

    function automatic longint unsigned cos_q30(input longint unsigned theta);
        longint unsigned sq;
        longint unsigned term;
        longint          sum;
        sq   = (theta * theta) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * sq) >> 30;
            case (n)
                1: term = term / 2;
                2: term = term / 12;
                3: term = term / 30;
                4: term = term / 56;
                5: term = term / 90;
                6: term = term / 132;
                default: term = term / 182;
            endcase
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    function automatic dist_tab_t build_dist();
        dist_tab_t       tab;
        longint unsigned theta;
        longint unsigned c;
        for (int d = 0; d <= HALF; d++)
        begin
            theta  = (longint'(d) * PI_Q30 + N_L / 2) / N_L;
            c      = cos_q30(theta);
            tab[d] = DIST_W'((c * 64'd12032 + (64'd1 << 29)) >> 30);
        end
        return tab;
    endfunction

    localparam ang_tab_t  ANG_TAB  = build_ang();
    localparam dist_tab_t DIST_TAB = build_dist();

    logic                        pick_valid;
    logic                        pick_ready;
    logic                        pick_found;
    logic [LW-1:0]               pick_p;
    logic [LW-1:0]               pick_q;
    logic [LW:0]                 sum_pq;
    logic [LW-1:0]               k_idx;
    logic [LW-1:0]               diff;
    logic [LW:0]                 diff_alt;
    logic [DW-1:0]               d_idx;
    logic                        out_valid_reg, out_valid_next;
    logic signed [ANGLE_W-1:0]   angle_reg, angle_next;
    logic [DIST_W-1:0]           dist_reg, dist_next;
    logic                        flag_reg, flag_next;

    rlsc_scan #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .samples    (samples),
        .pick_valid (pick_valid),
        .pick_ready (pick_ready),
        .pick_found (pick_found),
        .pick_p     (pick_p),
        .pick_q     (pick_q)
    );

    assign pick_ready = !out_valid_reg || results.ready;

    assign sum_pq   = {1'b0, pick_p} + {1'b0, pick_q};
    assign k_idx    = (sum_pq >= (LW+1)'(SENSOR_COUNT)) ?
                      LW'(sum_pq - (LW+1)'(SENSOR_COUNT)) : LW'(sum_pq);
    assign diff     = pick_q - pick_p;
    assign diff_alt = (LW+1)'(SENSOR_COUNT) - {1'b0, diff};
    assign d_idx    = ({1'b0, diff} <= diff_alt) ? DW'(diff) : DW'(diff_alt);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        angle_next     = angle_reg;
        dist_next      = dist_reg;
        flag_next      = flag_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pick_valid && pick_ready)
        begin
            out_valid_next = 1'b1;
            flag_next      = pick_found;
            angle_next     = pick_found ? ANG_TAB[k_idx] : '0;
            dist_next      = pick_found ? DIST_TAB[d_idx] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        dist_reg  <= dist_next;
        flag_reg  <= flag_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.chord_angle    = angle_reg;
    assign results.chord_distance = dist_reg;
    assign results.result_valid   = flag_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> (out_valid_reg && $stable(angle_reg)
            && $stable(dist_reg) && $stable(flag_reg)))
        else $error("pending result overwritten");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !flag_reg) |-> (angle_reg == '0 && dist_reg == '0))
        else $error("missing chord carries nonzero fields");
    a_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid && pick_ready) |=> out_valid_reg)
        else $error("picks taken without a result");
`endif
endmodule

// ----- src/rlsc_scan.sv -----
`timescale 1ns / 1ps
module rlsc_scan #(
    parameter int SENSOR_COUNT = rlsc_pkg::SENSOR_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rlsc_pkg::SAMPLE_W-1:0]       cfg_data,
    rlsc_sample_if.sink                         samples,
    output logic                                pick_valid,
    input  logic                                pick_ready,
    output logic                                pick_found,
    output logic [$clog2(SENSOR_COUNT)-1:0]     pick_p,
    output logic [$clog2(SENSOR_COUNT)-1:0]     pick_q
);
    import rlsc_pkg::*;

    localparam int LW = $clog2(SENSOR_COUNT);
    localparam int PW = $clog2(SENSOR_COUNT + 1);
    localparam int IW = $clog2(SENSOR_COUNT + 2);
    localparam logic [IW-1:0] N_I = IW'(SENSOR_COUNT);
    localparam logic [PW-1:0] N_P = PW'(SENSOR_COUNT);

    typedef enum logic [1:0] {S_LOAD, S_FIND1, S_FIND2, S_DONE} state_t;

    state_t                  state_reg, state_next;
    logic [SAMPLE_W-1:0]     thresh_reg, thresh_next;
    logic [SENSOR_COUNT-1:0] lit_reg, lit_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic [LW-1:0]           p_reg, p_next;
    logic [LW-1:0]           q_reg, q_next;
    logic                    found_reg, found_next;
    logic [IW-1:0]           idx_plus1;
    logic                    lit_here;
    logic                    lit_after;
    logic [LW-1:0]           chosen;

    // One index is examined per cycle; a neighbour past the ring reads unlit.
    assign idx_plus1 = idx_reg + IW'(1);
    assign lit_here  = (idx_reg < N_I) ? lit_reg[idx_reg[LW-1:0]] : 1'b0;
    assign lit_after = (idx_plus1 < N_I) ? lit_reg[idx_plus1[LW-1:0]] : 1'b0;
    assign chosen    = lit_after ? idx_plus1[LW-1:0] : idx_reg[LW-1:0];

    assign samples.ready = (state_reg == S_LOAD);
    assign pick_valid    = (state_reg == S_DONE);
    assign pick_found    = found_reg;
    assign pick_p        = p_reg;
    assign pick_q        = q_reg;

    always_comb
    begin
        state_next  = state_reg;
        thresh_next = cfg_we ? cfg_data : thresh_reg;
        lit_next    = lit_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        found_next  = found_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (samples.valid)
                begin
                    if (pos_reg < N_P)
                    begin
                        if (samples.sample > thresh_reg)
                        begin
                            lit_next[pos_reg[LW-1:0]] = 1'b1;
                        end
                        pos_next = pos_reg + PW'(1);
                    end
                    if (samples.last_sample)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = S_FIND1;
                    end
                end
            end
            S_FIND1:
            begin
                if (idx_reg >= N_I)
                begin
                    state_next = S_DONE;
                end
                else if (lit_here)
                begin
                    p_next     = chosen;
                    idx_next   = idx_reg + IW'(2);
                    state_next = S_FIND2;
                end
                else
                begin
                    idx_next = idx_plus1;
                end
            end
            S_FIND2:
            begin
                if (idx_reg >= N_I)
                begin
                    state_next = S_DONE;
                end
                else if (lit_here)
                begin
                    q_next     = chosen;
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_plus1;
                end
            end
            S_DONE:
            begin
                if (pick_ready)
                begin
                    lit_next   = '0;
                    pos_next   = '0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            thresh_reg <= THRESHOLD_RESET;
            lit_reg    <= '0;
            pos_reg    <= '0;
            idx_reg    <= '0;
            p_reg      <= '0;
            q_reg      <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            thresh_reg <= thresh_next;
            lit_reg    <= lit_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            p_reg      <= p_next;
            q_reg      <= q_next;
            found_reg  <= found_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid && pick_found) |-> (pick_q > pick_p))
        else $error("second pick does not follow the first");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= N_P)
        else $error("sensor position past the ring");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid && pick_ready) |=> (lit_reg == '0 && pos_reg == '0))
        else $error("lit map not cleared after a result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid && !pick_ready) |=> (pick_valid && $stable(pick_p) && $stable(pick_q)))
        else $error("picks changed while waiting");
`endif
endmodule

// ----- sim/ring_line_sensor_chord_locator_tb.sv -----
`timescale 1ns / 1ps
module ring_line_sensor_chord_locator_tb;
    import rlsc_pkg::*;

    localparam int N = SENSOR_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam longint unsigned PI29 = 64'd1686629713;
    localparam longint unsigned PI30 = 64'd3373259426;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } sample_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  distance;
        logic               ok;
    } chord_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SAMPLE_W-1:0] cfg_data;

    rlsc_sample_if samples ();
    rlsc_result_if results ();

    ring_line_sensor_chord_locator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .samples  (samples),
        .results  (results)
    );

    sample_t pending_samples[$];
    chord_t  expected_chords[$];

    logic [SAMPLE_W-1:0] threshold;
    logic [N-1:0] lit_marks;
    int      ring_pos;
    int      errors;
    bit      calm;
    int      send_gap;
    int      recv_gap;
    int      idle_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit marked(int idx);
        if (idx >= N)
            return 1'b0;
        return lit_marks[idx];
    endfunction

    function automatic longint unsigned cosine_q30(longint unsigned theta);
        longint unsigned sq;
        longint unsigned term;
        longint sum;
        sq = (theta * theta) >> 30;
        term = 64'd1 << 30;
        sum = 64'sd1 << 30;
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * sq) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    function automatic chord_t locate_chord();
        chord_t r;
        int f1;
        int f2;
        int p;
        int q;
        int k;
        int d;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned c;
        r = '0;
        f1 = -1;
        f2 = -1;
        for (int i = 0; i < N; i++)
            if (f1 < 0 && marked(i))
                f1 = i;
        if (f1 >= 0)
        begin
            p = marked(f1 + 1) ? f1 + 1 : f1;
            for (int i = f1 + 2; i < N; i++)
                if (f2 < 0 && marked(i))
                    f2 = i;
        end
        if (f2 >= 0)
        begin
            q = marked(f2 + 1) ? f2 + 1 : f2;
            k = (p + q) % N;
            d = (q - p <= N - (q - p)) ? q - p : N - (q - p);
            den = longint'(N) << 16;
            if (2 * k < N)
                mag = (longint'(k) * PI29 + den / 2) / den;
            else
                mag = -((longint'(N - k) * PI29 + den / 2) / den);
            r.angle = mag[ANGLE_W-1:0];
            c = cosine_q30((longint'(d) * PI30 + N / 2) / N);
            c = (c * (47 * 256) + (64'd1 << 29)) >> 30;
            r.distance = c[DIST_W-1:0];
            r.ok = 1'b1;
        end
        return r;
    endfunction

    task automatic queue_sample(logic [SAMPLE_W-1:0] value, logic last);
        sample_t s;
        s.sample = value;
        s.last = last;
        pending_samples.push_back(s);
        if (ring_pos < N)
        begin
            if (value > threshold)
                lit_marks[ring_pos] = 1'b1;
            ring_pos++;
        end
        if (last)
        begin
            expected_chords.push_back(locate_chord());
            lit_marks = '0;
            ring_pos = 0;
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] random_level();
        case ($urandom_range(0, 3))
            0: return SAMPLE_W'($urandom_range(0, threshold));
            1: return (threshold == 10'h3FF) ? 10'h3FF
                      : SAMPLE_W'($urandom_range(threshold + 1, 1023));
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic queue_ring(int len, int lit_pct);
        for (int i = 0; i < len; i++)
        begin
            logic [SAMPLE_W-1:0] v;
            if ($urandom_range(0, 99) < lit_pct)
                v = (threshold == 10'h3FF) ? 10'h3FF
                    : SAMPLE_W'($urandom_range(threshold + 1, 1023));
            else if ($urandom_range(0, 4) == 0)
                v = random_level();
            else
                v = SAMPLE_W'($urandom_range(0, threshold));
            queue_sample(v, i == len - 1);
        end
    endtask

    task automatic queue_lit_set(logic [N-1:0] set, int len);
        for (int i = 0; i < len; i++)
            queue_sample(set[i] ? 10'h3FF : 10'h000, i == len - 1);
    endtask

    task automatic drain_and_set(logic [SAMPLE_W-1:0] value);
        while (pending_samples.size() != 0 || expected_chords.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold = value;
    endtask

    always @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            pending_samples.pop_front();
        if (!(samples.valid && !samples.ready) && send_gap == 0 && !calm
            && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 4);
        if (samples.valid && !samples.ready)
            ;
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            samples.valid <= 1'b0;
        end
        else if (pending_samples.size() > (samples.valid && samples.ready ? 0 : 0))
        begin
            samples.valid <= 1'b1;
            samples.sample <= pending_samples[0].sample;
            samples.last_sample <= pending_samples[0].last;
        end
        else
            samples.valid <= 1'b0;
    end

    always @(posedge clk)
    begin
        chord_t e;
        if (results.valid && results.ready)
        begin
            if (expected_chords.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                e = expected_chords.pop_front();
                if (results.chord_angle !== e.angle)
                begin
                    $error("chord_angle expected %0d actual %0d", $signed(e.angle),
                           results.chord_angle);
                    errors++;
                end
                if (results.chord_distance !== e.distance)
                begin
                    $error("chord_distance expected %0d actual %0d", e.distance,
                           results.chord_distance);
                    errors++;
                end
                if (results.result_valid !== e.ok)
                begin
                    $error("result_valid expected %0d actual %0d", e.ok,
                           results.result_valid);
                    errors++;
                end
            end
        end
        if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            results.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            recv_gap <= $urandom_range(0, 3);
            results.ready <= 1'b0;
        end
        else
            results.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [N-1:0] set;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.sample = '0;
        samples.last_sample = 1'b0;
        results.ready = 1'b0;
        errors = 0;
        calm = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        idle_cycles = 0;
        threshold = THRESHOLD_RESET;
        lit_marks = '0;
        ring_pos = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_sample(10'd701, 1'b0);
        queue_sample(10'd700, 1'b0);
        queue_sample(10'h3FF, 1'b0);
        queue_sample(10'h000, 1'b1);
        set = '0;
        set[0] = 1'b1;
        set[15] = 1'b1;
        queue_lit_set(set, N);
        set = '0;
        set[28] = 1'b1;
        set[29] = 1'b1;
        set[5] = 1'b1;
        queue_lit_set(set, N + 3);
        set = '0;
        set[1] = 1'b1;
        set[29] = 1'b1;
        queue_lit_set(set, N);
        queue_lit_set('1, N);
        queue_lit_set('0, N);
        queue_sample(10'h3FF, 1'b1);

        drain_and_set(10'd0);
        queue_ring(N, 10);
        drain_and_set(10'h3FF);
        queue_ring(N, 0);
        drain_and_set(10'd512);
        queue_ring(N, 20);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_and_set(phase == 3 ? THRESHOLD_RESET : 10'($urandom_range(0, 1023)));
            for (int r = 0; r < 6; r++)
            begin
                case ($urandom_range(0, 5))
                    0: queue_ring($urandom_range(1, N - 1), 15);
                    1: queue_ring($urandom_range(N + 1, N + 4), 15);
                    default: queue_ring(N, $urandom_range(3, 30));
                endcase
            end
            if (phase == 3)
                calm = 1'b1;
        end

        while (pending_samples.size() != 0 || expected_chords.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
